FILE: src/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

    // Constants of the range reduction: 1/(2*pi) in Q.32, the rest in Q.30
    localparam logic signed [62:0] INV_TWO_PI_Q32 = 63'sd683565275;
    localparam logic [33:0]        TWO_PI_Q30     = 34'd6746518852;
    localparam logic signed [33:0] PI_Q30         = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30    = 34'sd1686629713;

    // Horner seeds (highest-order coefficients)
    localparam logic signed [31:0] SIN_SEED = -32'sd26;
    localparam logic signed [31:0] COS_SEED = -32'sd280;

    // Constants added after each Horner multiply, lowest step first
    localparam int NUM_STEPS = 5;
    localparam logic signed [31:0] SIN_ADD [NUM_STEPS] = '{
        32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
    };
    localparam logic signed [31:0] COS_ADD [NUM_STEPS] = '{
        32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
    };

    // One item inside the polynomial part of the pipe
    typedef struct packed {
        logic signed [31:0] p;      // sine accumulator, Q.30
        logic signed [31:0] c;      // cosine accumulator, Q.30
        logic signed [31:0] y;      // folded angle, Q.30
        logic signed [32:0] y2;     // y squared, Q.30
        logic               flip;   // cosine sign flip from the fold
    } lane_t;

    // Load enables of the two registers of one Horner step
    typedef struct packed {
        logic mul;
        logic add;
    } step_ld_t;

    // Q.30 product back to Q.30: round to nearest, ties away from zero
    function automatic logic signed [35:0] rnd_q30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd536870912 - 66'(v[65]);
        return t[65:30];
    endfunction

endpackage

FILE: src/scp_reduce.sv
`timescale 1ns / 1ps

// Range reduction: five register stages from angle to folded y in [-pi/2, pi/2]
module scp_reduce #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic [4:0]         ld,
    input  logic signed [31:0] angle,
    output logic signed [31:0] y,
    output logic               flip
);

    localparam int QS = ANGLE_FRAC_BITS + 32;
    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam logic [62:0] Q_HALF = 63'(1) << (QS - 1);
    localparam logic signed [62:0] INV_TWO_PI_Q32_C = scp_pkg::INV_TWO_PI_Q32;

    logic signed [62:0] m_reg, m_next;
    logic signed [31:0] a1_reg, a2_reg;
    logic signed [15:0] q_reg, q_next;
    logic signed [62:0] q_sum;
    logic [33:0]        qp_reg, qp_next;
    logic signed [31:0] a3_reg;
    logic signed [33:0] y3_reg, y3_next;
    logic [33:0]        a_sh;
    logic signed [31:0] y4_reg, y4_next;
    logic               flip_reg, flip_next;

    // stage 0: angle times 1/(2*pi)
    assign m_next = angle * INV_TWO_PI_Q32_C;

    // stage 1: round quotient half away from zero
    always_comb
    begin
        q_sum  = m_reg + Q_HALF - 63'(m_reg[62]);
        q_next = 16'(q_sum >>> QS);
    end

    // stage 2: quotient times 2*pi, low bits only (remainder is small)
    assign qp_next = 34'(q_reg) * scp_pkg::TWO_PI_Q30;

    // stage 3: remainder in Q.30
    always_comb
    begin
        a_sh    = 34'(a3_reg) << SH;
        y3_next = a_sh - qp_reg;
    end

    // stage 4: fold toward +/-pi
    always_comb
    begin
        flip_next = 1'b0;
        y4_next   = 32'(y3_reg);
        if (y3_reg > scp_pkg::HALF_PI_Q30)
        begin
            y4_next   = 32'(scp_pkg::PI_Q30 - y3_reg);
            flip_next = 1'b1;
        end
        else if (y3_reg < -scp_pkg::HALF_PI_Q30)
        begin
            y4_next   = 32'(-scp_pkg::PI_Q30 - y3_reg);
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            m_reg  <= m_next;
            a1_reg <= angle;
        end
        if (ld[1])
        begin
            q_reg  <= q_next;
            a2_reg <= a1_reg;
        end
        if (ld[2])
        begin
            qp_reg <= qp_next;
            a3_reg <= a2_reg;
        end
        if (ld[3])
        begin
            y3_reg <= y3_next;
        end
        if (ld[4])
        begin
            y4_reg   <= y4_next;
            flip_reg <= flip_next;
        end
    end

    assign y    = y4_reg;
    assign flip = flip_reg;

endmodule

FILE: src/scp_hstep.sv
`timescale 1ns / 1ps

// One Horner step for sine and cosine: multiply by y2, then round and add
module scp_hstep #(
    parameter logic signed [31:0] ADD_SIN = 32'sd0,
    parameter logic signed [31:0] ADD_COS = 32'sd0
) (
    input  logic             clk,
    input  scp_pkg::step_ld_t ld,
    input  scp_pkg::lane_t   lane_in,
    output scp_pkg::lane_t   lane_out
);

    logic signed [64:0] ps_reg, ps_next;
    logic signed [64:0] pc_reg, pc_next;
    scp_pkg::lane_t     mid_reg;
    scp_pkg::lane_t     out_reg, out_next;
    logic signed [35:0] rs, rc;

    // multiply stage
    always_comb
    begin
        ps_next = lane_in.p * lane_in.y2;
        pc_next = lane_in.c * lane_in.y2;
    end

    // round and add stage
    always_comb
    begin
        rs         = scp_pkg::rnd_q30(66'(ps_reg));
        rc         = scp_pkg::rnd_q30(66'(pc_reg));
        out_next   = mid_reg;
        out_next.p = 32'(rs + 36'(ADD_SIN));
        out_next.c = 32'(rc + 36'(ADD_COS));
    end

    always_ff @(posedge clk)
    begin
        if (ld.mul)
        begin
            ps_reg  <= ps_next;
            pc_reg  <= pc_next;
            mid_reg <= lane_in;
        end
        if (ld.add)
        begin
            out_reg <= out_next;
        end
    end

    assign lane_out = out_reg;

endmodule

FILE: src/sine_cosine_polynomial.sv
`timescale 1ns / 1ps
// Pipeline: 20 register stages between the angle input and the result outputs.
// Throughput: one angle per clock unless the output stalls; the multiplier chain (range
//   reduction, y squared, five Horner steps, final multiply by y) is fully pipelined.
// A stalled result holds; upstream stages keep filling empty slots until all are full.
// Reset: rst_n (async, active low) clears the stage valid bits only.
module sine_cosine_polynomial #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_stall,
    input  logic signed [31:0] angle,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] sine_value,
    output logic signed [31:0] cosine_value
);

    localparam int NSTAGE    = 20;
    localparam int ST_YY     = 5;
    localparam int ST_Y2     = 6;
    localparam int ST_H0     = 7;
    localparam int ST_FMUL   = ST_H0 + 2 * scp_pkg::NUM_STEPS;
    localparam int ST_FRND   = ST_FMUL + 1;
    localparam int ST_OUT    = ST_FRND + 1;
    localparam int OUT_SHIFT = 30 - RESULT_FRAC_BITS;
    localparam logic [34:0] OUT_HALF =
        (OUT_SHIFT == 0) ? 35'(0) : (35'(1) << (OUT_SHIFT - 1));
    localparam logic signed [34:0] OUT_LIM = 35'sd1 <<< RESULT_FRAC_BITS;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] ld;

    // A stage loads unless it and everything after it is full and the output stalls
    always_comb
    begin
        for (int k = 0; k < NSTAGE; k++)
        begin
            ld[k] = !result_stall ||
                    !(&(vld_reg | NSTAGE'((64'(1) << k) - 64'(1))));
        end
    end

    assign angle_stall  = !ld[0];
    assign result_valid = vld_reg[ST_OUT];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= angle_valid;
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (ld[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // range reduction, stages 0 to 4
    logic signed [31:0] y_red;
    logic               flip_red;

    scp_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk  (clk),
        .ld   (ld[4:0]),
        .angle(angle),
        .y    (y_red),
        .flip (flip_red)
    );

    // y squared: multiply, then round
    logic signed [63:0] yy_reg, yy_next;
    logic signed [31:0] y5_reg;
    logic               flip5_reg;
    scp_pkg::lane_t     lane [scp_pkg::NUM_STEPS+1];
    scp_pkg::lane_t     seed_reg, seed_next;
    logic signed [35:0] y2_full;

    assign yy_next = y_red * y_red;

    always_comb
    begin
        y2_full        = scp_pkg::rnd_q30(66'(yy_reg));
        seed_next.p    = scp_pkg::SIN_SEED;
        seed_next.c    = scp_pkg::COS_SEED;
        seed_next.y    = y5_reg;
        seed_next.y2   = 33'(y2_full);
        seed_next.flip = flip5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_YY])
        begin
            yy_reg    <= yy_next;
            y5_reg    <= y_red;
            flip5_reg <= flip_red;
        end
        if (ld[ST_Y2])
        begin
            seed_reg <= seed_next;
        end
    end

    assign lane[0] = seed_reg;

    // Horner steps, two stages each
    for (genvar i = 0; i < scp_pkg::NUM_STEPS; i++)
    begin : g_step
        scp_pkg::step_ld_t step_ld;
        assign step_ld.mul = ld[ST_H0 + 2*i];
        assign step_ld.add = ld[ST_H0 + 2*i + 1];

        scp_hstep #(
            .ADD_SIN(scp_pkg::SIN_ADD[i]),
            .ADD_COS(scp_pkg::COS_ADD[i])
        ) u_hstep (
            .clk     (clk),
            .ld      (step_ld),
            .lane_in (lane[i]),
            .lane_out(lane[i+1])
        );
    end

    // sine times y, cosine sign
    logic signed [63:0] sp_reg, sp_next;
    logic signed [31:0] cf_reg;
    logic               flipf_reg;
    logic signed [33:0] s_reg, s_next;
    logic signed [33:0] c_reg, c_next;
    logic signed [35:0] sp_rnd;

    assign sp_next = lane[scp_pkg::NUM_STEPS].p * lane[scp_pkg::NUM_STEPS].y;

    always_comb
    begin
        sp_rnd = scp_pkg::rnd_q30(66'(sp_reg));
        s_next = 34'(sp_rnd);
        c_next = flipf_reg ? -34'(cf_reg) : 34'(cf_reg);
    end

    // round to result format and saturate to +/-1
    function automatic logic signed [31:0] to_out(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] r;
        t = 35'(v) + OUT_HALF - ((OUT_SHIFT != 0) ? 35'(v[33]) : 35'(0));
        r = t >>> OUT_SHIFT;
        if (r > OUT_LIM)
            r = OUT_LIM;
        else if (r < -OUT_LIM)
            r = -OUT_LIM;
        return 32'(r);
    endfunction

    logic signed [31:0] sine_reg, cosine_reg;

    always_ff @(posedge clk)
    begin
        if (ld[ST_FMUL])
        begin
            sp_reg    <= sp_next;
            cf_reg    <= lane[scp_pkg::NUM_STEPS].c;
            flipf_reg <= lane[scp_pkg::NUM_STEPS].flip;
        end
        if (ld[ST_FRND])
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
        if (ld[ST_OUT])
        begin
            sine_reg   <= to_out(s_reg);
            cosine_reg <= to_out(c_reg);
        end
    end

    assign sine_value   = sine_reg;
    assign cosine_value = cosine_reg;

    // input is held off only when the whole pipe is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> (result_stall && (&vld_reg)))
        else $error("input stalled while the pipe has room");

    // items in flight change only by transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ($countones(vld_reg) == $past($countones(vld_reg))
                   + int'($past(angle_valid && !angle_stall))
                   - int'($past(result_valid && !result_stall))))
        else $error("item lost or duplicated in the pipe");

    // results stay within +/-1
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (35'(sine_value) <= OUT_LIM && 35'(sine_value) >= -OUT_LIM
                          && 35'(cosine_value) <= OUT_LIM
                          && 35'(cosine_value) >= -OUT_LIM))
        else $error("result outside saturation range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;

    // Range reduction constants: 1/(2*pi) in Q.32, the rest in Q.30
    localparam longint RECIP_TWO_PI = 64'sd683565275;
    localparam longint TWO_PI_FIX   = 64'sd6746518852;
    localparam longint PI_FIX       = 64'sd3373259426;
    localparam longint HALF_PI_FIX  = 64'sd1686629713;
    localparam longint ONE_FIX      = 64'sd1073741824;

    // Sine Horner coefficients, highest order first, Q.30
    localparam longint SINE_T5 = -64'sd26;
    localparam longint SINE_T4 = 64'sd2956;
    localparam longint SINE_T3 = 64'sd213040;
    localparam longint SINE_T2 = 64'sd8947846;
    localparam longint SINE_T1 = 64'sd178956974;

    // Cosine Horner coefficients, highest order first, Q.30
    localparam longint COSINE_T5 = -64'sd280;
    localparam longint COSINE_T4 = 64'sd26586;
    localparam longint COSINE_T3 = 64'sd1491253;
    localparam longint COSINE_T2 = 64'sd44739212;
    localparam longint COSINE_T1 = 64'sd536870912;

    // Landmarks of the angle input in Q7.24
    localparam longint TWO_PI_ANGLE  = 64'sd105414357;
    localparam longint PI_ANGLE      = 64'sd52707179;
    localparam longint HALF_PI_ANGLE = 64'sd26353589;

    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_ITEMS     = 80;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_ROWS       = 21;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
        logic               folded;
    } sincos_t;

    typedef struct packed {
        logic               typed;
        logic signed [31:0] angle;
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } angle_row_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               angle_valid  = 1'b0;
    logic               angle_stall;
    logic signed [31:0] angle        = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] sine_value;
    logic signed [31:0] cosine_value;

    sincos_t expected_trig [$];
    sincos_t oldest_trig;
    int      fail_count    = 0;
    int      sent_count    = 0;
    int      checked_count = 0;
    int      folded_count  = 0;
    int      idle_cycles   = 0;
    int      burst_left    = 0;
    bit      hold_requested = 1'b0;
    bit      hold_active    = 1'b0;

    // Directed angles; only the zero angle carries a hand-written result
    angle_row_t directed_rows [NUM_ROWS] = '{
        '{1'b1, 32'sd0,            32'sd0, 32'sd1073741824},
        '{1'b0, 32'sd1,            32'sd0, 32'sd0},
        '{1'b0, -32'sd1,           32'sd0, 32'sd0},
        '{1'b0, 32'sh7FFFFFFF,     32'sd0, 32'sd0},
        '{1'b0, 32'sh80000000,     32'sd0, 32'sd0},
        '{1'b0, 32'sh80000001,     32'sd0, 32'sd0},
        '{1'b0, 32'sd26353589,     32'sd0, 32'sd0},
        '{1'b0, 32'sd26353590,     32'sd0, 32'sd0},
        '{1'b0, -32'sd26353589,    32'sd0, 32'sd0},
        '{1'b0, -32'sd26353590,    32'sd0, 32'sd0},
        '{1'b0, 32'sd52707179,     32'sd0, 32'sd0},
        '{1'b0, 32'sd52707180,     32'sd0, 32'sd0},
        '{1'b0, -32'sd52707179,    32'sd0, 32'sd0},
        '{1'b0, -32'sd52707180,    32'sd0, 32'sd0},
        '{1'b0, 32'sd105414357,    32'sd0, 32'sd0},
        '{1'b0, -32'sd105414357,   32'sd0, 32'sd0},
        '{1'b0, 32'sd158121537,    32'sd0, 32'sd0},
        '{1'b0, 32'sd16777216,     32'sd0, 32'sd0},
        '{1'b0, -32'sd16777216,    32'sd0, 32'sd0},
        '{1'b0, 32'sh55555555,     32'sd0, 32'sd0},
        '{1'b0, 32'shAAAAAAAA,     32'sd0, 32'sd0}
    };

    sine_cosine_polynomial #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angle        (angle),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sine_value   (sine_value),
        .cosine_value (cosine_value)
    );

    // Divide by 2^s, round to nearest, ties away from zero
    function automatic longint round_down_by(input longint v, input int s);
        logic [63:0] mag;
        bit          neg;
        if (s == 0)
            return v;
        neg = v < 0;
        mag = neg ? unsigned'(-v) : unsigned'(v);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return neg ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return round_down_by(a * b, 30);
    endfunction

    // Q.30 to output format, clamped to +/-1
    function automatic logic signed [31:0] to_result_format(input longint v);
        longint lim;
        longint r;
        lim = longint'(1) << RESULT_FRAC_BITS;
        r = round_down_by(v, 30 - RESULT_FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[31:0];
    endfunction

    // Sine and cosine of one Q7.24 angle
    function automatic sincos_t predict_sincos(input logic signed [31:0] theta);
        sincos_t res;
        longint  a;
        longint  q;
        longint  y;
        longint  y2;
        longint  s;
        longint  c;
        a = longint'(theta);
        res.folded = 1'b0;

        // nearest multiple of 2*pi, then fold into [-pi/2, pi/2]
        q = round_down_by(a * RECIP_TWO_PI, ANGLE_FRAC_BITS + 32);
        y = a * (longint'(1) << (30 - ANGLE_FRAC_BITS)) - q * TWO_PI_FIX;
        if (y > HALF_PI_FIX) begin
            y = PI_FIX - y;
            res.folded = 1'b1;
        end else if (y < -HALF_PI_FIX) begin
            y = -PI_FIX - y;
            res.folded = 1'b1;
        end
        y2 = fix_mul(y, y);

        s = SINE_T5;
        s = fix_mul(s, y2) + SINE_T4;
        s = fix_mul(s, y2) - SINE_T3;
        s = fix_mul(s, y2) + SINE_T2;
        s = fix_mul(s, y2) - SINE_T1;
        s = fix_mul(s, y2) + ONE_FIX;
        s = fix_mul(s, y);

        c = COSINE_T5;
        c = fix_mul(c, y2) + COSINE_T4;
        c = fix_mul(c, y2) - COSINE_T3;
        c = fix_mul(c, y2) + COSINE_T2;
        c = fix_mul(c, y2) - COSINE_T1;
        c = fix_mul(c, y2) + ONE_FIX;
        if (res.folded)
            c = -c;

        res.sine   = to_result_format(s);
        res.cosine = to_result_format(c);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Angles biased toward fold points, small angles and the range ends
    function automatic logic signed [31:0] random_angle();
        longint base;
        longint jitter;
        int     pick;
        int     k;
        pick   = $urandom_range(0, 99);
        k      = int'($urandom_range(0, 38)) - 19;
        jitter = longint'($urandom_range(0, 256)) - 128;
        if (pick < 30)
            base = longint'($urandom);
        else if (pick < 55)
            base = longint'($urandom_range(0, 134217727)) - 67108864;
        else if (pick < 75)
            base = longint'(k) * TWO_PI_ANGLE + jitter
                   + ($urandom_range(0, 1) ? HALF_PI_ANGLE : -HALF_PI_ANGLE);
        else if (pick < 90)
            base = longint'(k) * TWO_PI_ANGLE + jitter
                   + ($urandom_range(0, 1) ? PI_ANGLE : -PI_ANGLE);
        else if (pick < 95)
            base = longint'($urandom_range(0, 511)) - 256;
        else if ($urandom_range(0, 1))
            base = 64'sd2147483647 - longint'($urandom_range(0, 1023));
        else
            base = -64'sd2147483648 + longint'($urandom_range(0, 1023));
        return base[31:0];
    endfunction

    // Offer one angle, wait for the transfer, record its expected result
    task automatic send_angle(input logic signed [31:0] value, input bit typed,
                              input sincos_t typed_result, input bit back_to_back);
        sincos_t prediction;
        int      gap;
        angle_valid <= 1'b1;
        angle       <= value;
        @(posedge clk);
        while (angle_stall)
            @(posedge clk);
        prediction = predict_sincos(value);
        if (typed) begin
            prediction.sine   = typed_result.sine;
            prediction.cosine = typed_result.cosine;
        end
        expected_trig.push_back(prediction);
        sent_count++;
        if (prediction.folded)
            folded_count++;

        if (back_to_back)
            gap = 0;
        else if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = idle_length();
            if ($urandom_range(0, 49) == 0)
                burst_left = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            angle_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus
    initial begin
        sincos_t typed_result;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed angles
        for (int i = 0; i < NUM_ROWS; i++) begin
            typed_result.sine   = directed_rows[i].sine;
            typed_result.cosine = directed_rows[i].cosine;
            typed_result.folded = 1'b0;
            send_angle(directed_rows[i].angle, directed_rows[i].typed, typed_result, 1'b0);
        end

        // pause until the pipe has drained
        angle_valid <= 1'b0;
        while (expected_trig.size() != 0)
            @(posedge clk);

        // receiver holds off while angles keep coming, so the pipe fills
        hold_requested = 1'b1;
        while (!hold_active)
            @(posedge clk);
        for (int i = 0; i < HOLD_ITEMS; i++)
            send_angle(random_angle(), 1'b0, '0, 1'b1);

        // random angles with random gaps
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_angle(random_angle(), 1'b0, '0, 1'b0);
        angle_valid <= 1'b0;

        while (expected_trig.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d angles sent, %0d of them folded toward +/-pi; %0d results checked",
                 sent_count, folded_count, checked_count);
        $display("covered range ends, fold points, a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int run_len;
        int shut;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (hold_requested) begin
                hold_active  = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_requested = 1'b0;
                hold_active    = 1'b0;
            end else begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(1, 8);
                result_stall <= 1'b0;
                repeat (run_len) @(posedge clk);
                shut = idle_length();
                if (shut > 0) begin
                    result_stall <= 1'b1;
                    repeat (shut) @(posedge clk);
                end
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (expected_trig.size() == 0) begin
                $error("unexpected result: sine_value %0d cosine_value %0d",
                       sine_value, cosine_value);
                fail_count++;
            end else begin
                oldest_trig = expected_trig.pop_front();
                checked_count++;
                if (sine_value !== oldest_trig.sine) begin
                    $error("sine_value: expected %0d, got %0d", oldest_trig.sine, sine_value);
                    fail_count++;
                end
                if (cosine_value !== oldest_trig.cosine) begin
                    $error("cosine_value: expected %0d, got %0d",
                           oldest_trig.cosine, cosine_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((angle_valid && !angle_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d results still pending", expected_trig.size());
                $display("tb failed");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
